// File: sv/qbp_pkg.sv
// ----------------------------------------------------------------------------
// qbp_pkg
// Shared types and constants for the quantizing bit packer.
// ----------------------------------------------------------------------------
package qbp_pkg;

    localparam int SAMPLE_WIDTH  = 32;
    localparam int MAX_CODE_BITS = 30;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int NB_W          = 5;
    localparam int RANGE_W       = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int ALU_W         = 64;
    localparam int DIV_STEPS     = ALU_W;
    localparam int BUF_W         = MAX_CODE_BITS + 7;
    localparam int CNT_W         = 6;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX      = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           final_sample;
    } in_word_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       stream_end;
    } out_word_t;

    // quantiser to packer hand-over
    typedef struct packed {
        logic              load;
        logic [CODE_W-1:0] code;
        logic [NB_W-1:0]   nb;
        logic              fin;
    } code_word_t;

endpackage

// File: sv/qbp_alu.sv
// ----------------------------------------------------------------------------
// qbp_alu
// Shared 64-bit add/subtract unit used by the quantiser's arithmetic steps.
// ----------------------------------------------------------------------------
module qbp_alu (
    input  logic [qbp_pkg::ALU_W-1:0] op_a,
    input  logic [qbp_pkg::ALU_W-1:0] op_b,
    input  logic                      sub,
    output logic [qbp_pkg::ALU_W-1:0] sum
);
    import qbp_pkg::*;

    logic [ALU_W-1:0] op_b_inv;

    assign op_b_inv = sub ? ~op_b : op_b;
    assign sum      = op_a + op_b_inv + {{(ALU_W-1){1'b0}}, sub};

endmodule

// File: sv/qbp_quantizer.sv
// ----------------------------------------------------------------------------
// qbp_quantizer
// Sequencer that maps one sample onto a code through the shared adder,
// including a restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qbp_quantizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qbp_pkg::in_word_t                  in_data,
    input  logic [qbp_pkg::NB_W-1:0]           nb,
    input  logic signed [qbp_pkg::RANGE_W-1:0] range_min,
    input  logic signed [qbp_pkg::RANGE_W-1:0] range_max,
    input  logic                               pack_idle,
    output qbp_pkg::code_word_t                code_o
);
    import qbp_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIFF = 4'd1;
    localparam logic [3:0] ST_LO   = 4'd2;
    localparam logic [3:0] ST_HI   = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_ABSN = 4'd6;
    localparam logic [3:0] ST_ABSD = 4'd7;
    localparam logic [3:0] ST_DVD  = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_SIGN = 4'd10;
    localparam logic [3:0] ST_CODE = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic [3:0]                      state_reg, state_next;
    logic signed [SAMPLE_WIDTH-1:0]  x_reg, x_next;
    logic                            fin_reg, fin_next;
    logic [ALU_W-1:0]                a_reg, a_next;
    logic [ALU_W-1:0]                b_reg, b_next;
    logic [ALU_W-1:0]                d_reg, d_next;
    logic                            lower_reg, lower_next;
    logic                            zero_reg, zero_next;
    logic                            negn_reg, negn_next;
    logic                            negd_reg, negd_next;
    logic [STEP_W-1:0]               step_reg, step_next;
    logic [CODE_W-1:0]               code_reg, code_next;

    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub;
    logic [ALU_W-1:0] x_ext, min_ext, max_ext, rem_sh;
    logic [CODE_W-1:0] mask;
    logic             load;

    assign x_ext   = ALU_W'(x_reg);
    assign min_ext = ALU_W'(range_min);
    assign max_ext = ALU_W'(range_max);
    assign mask    = ~({CODE_W{1'b1}} << nb);
    assign rem_sh  = {a_reg[ALU_W-2:0], b_reg[ALU_W-1]};

    qbp_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum)
    );

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        fin_next   = fin_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        lower_next = lower_reg;
        zero_next  = zero_reg;
        negn_next  = negn_reg;
        negd_next  = negd_reg;
        step_next  = step_reg;
        code_next  = code_reg;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b1;
        load       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    x_next     = in_data.sample;
                    fin_next   = in_data.final_sample;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                alu_a      = max_ext;
                alu_b      = min_ext;
                d_next     = alu_sum;
                zero_next  = (alu_sum == '0);
                state_next = ST_LO;
            end
            ST_LO: begin
                alu_a      = x_ext;
                alu_b      = min_ext;
                a_next     = alu_sum;
                state_next = ST_HI;
            end
            ST_HI: begin
                alu_a      = max_ext;
                alu_b      = x_ext;
                b_next     = alu_sum;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // below midpoint when (x - min) < (max - x)
                alu_a      = a_reg;
                alu_b      = b_reg;
                lower_next = alu_sum[ALU_W-1];
                a_next     = alu_sum[ALU_W-1] ? a_reg : b_reg;
                if (zero_reg) begin
                    code_next  = '0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // distance * mask as (distance << nb) - distance
                alu_a      = a_reg << nb;
                alu_b      = a_reg;
                a_next     = alu_sum;
                state_next = ST_ABSN;
            end
            ST_ABSN: begin
                alu_b      = a_reg;
                negn_next  = a_reg[ALU_W-1];
                a_next     = a_reg[ALU_W-1] ? alu_sum : a_reg;
                state_next = ST_ABSD;
            end
            ST_ABSD: begin
                alu_b      = d_reg;
                negd_next  = d_reg[ALU_W-1];
                d_next     = d_reg[ALU_W-1] ? alu_sum : d_reg;
                state_next = ST_DVD;
            end
            ST_DVD: begin
                // dividend 2|n| + |d|, divisor 2|d|
                alu_a      = a_reg << 1;
                alu_b      = d_reg;
                alu_sub    = 1'b0;
                b_next     = alu_sum;
                d_next     = d_reg << 1;
                a_next     = '0;
                step_next  = STEP_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                alu_a     = rem_sh;
                alu_b     = d_reg;
                a_next    = alu_sum[ALU_W-1] ? rem_sh : alu_sum;
                b_next    = {b_reg[ALU_W-2:0], ~alu_sum[ALU_W-1]};
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                alu_b      = b_reg;
                b_next     = (negn_reg ^ negd_reg) ? alu_sum : b_reg;
                state_next = ST_CODE;
            end
            ST_CODE: begin
                alu_a      = ALU_W'(mask);
                alu_b      = b_reg;
                code_next  = (lower_reg ? b_reg[CODE_W-1:0] : alu_sum[CODE_W-1:0]) & mask;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (pack_idle) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg     <= x_next;
        fin_reg   <= fin_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        d_reg     <= d_next;
        lower_reg <= lower_next;
        zero_reg  <= zero_next;
        negn_reg  <= negn_next;
        negd_reg  <= negd_next;
        step_reg  <= step_next;
        code_reg  <= code_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign code_o.load = load;
    assign code_o.code = code_reg;
    assign code_o.nb   = nb;
    assign code_o.fin  = fin_reg;

endmodule

// File: sv/qbp_packer.sv
// ----------------------------------------------------------------------------
// qbp_packer
// Bit accumulator: appends codes MSB first; drains whole bytes, one per cycle
// while m_ready allows, to the output register; pads a final sample's tail.
// ----------------------------------------------------------------------------
module qbp_packer (
    input  logic                aclk,
    input  logic                aresetn,
    input  qbp_pkg::code_word_t code_i,
    output logic                idle,
    output logic                m_valid,
    input  logic                m_ready,
    output qbp_pkg::out_word_t  m_data
);
    import qbp_pkg::*;

    localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              flush_reg, flush_next;
    logic              valid_reg, valid_next;
    out_word_t         data_reg, data_next;

    logic              slot_free;
    logic [BUF_W-1:0]  full_sh;
    logic [BUF_W-1:0]  pad_sh;

    assign slot_free = !valid_reg || m_ready;
    assign full_sh   = buf_reg >> (cnt_reg - BYTE_BITS);
    assign pad_sh    = buf_reg << (4'd8 - {1'b0, cnt_reg[2:0]});
    assign idle      = (cnt_reg < BYTE_BITS) && !flush_reg;

    always_comb begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        valid_next = valid_reg && !m_ready;
        data_next  = data_reg;

        if (code_i.load) begin
            buf_next   = (buf_reg << code_i.nb) | BUF_W'(code_i.code);
            cnt_next   = cnt_reg + CNT_W'(code_i.nb);
            flush_next = code_i.fin;
        end else if (slot_free && cnt_reg >= BYTE_BITS) begin
            cnt_next              = cnt_reg - BYTE_BITS;
            valid_next            = 1'b1;
            data_next.packed_byte = full_sh[7:0] & BYTE_MASK;
            data_next.stream_end  = flush_reg && (cnt_reg == BYTE_BITS);
            if (flush_reg && cnt_reg == BYTE_BITS) begin
                flush_next = 1'b0;
                buf_next   = '0;
            end
        end else if (flush_reg && cnt_reg == '0) begin
            flush_next = 1'b0;
            buf_next   = '0;
        end else if (slot_free && flush_reg) begin
            // zero-padded tail byte
            valid_next            = 1'b1;
            data_next.packed_byte = pad_sh[7:0] & BYTE_MASK;
            data_next.stream_end  = 1'b1;
            cnt_next              = '0;
            buf_next              = '0;
            flush_next            = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg   <= '0;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: sv/quantize_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// quantize_bit_packer_unit
// Quantises signed Q16.16 samples to bits_per_value-bit codes and packs them
// MSB first into a byte stream.
// ----------------------------------------------------------------------------
// Each sample word passes from acceptance to code through eleven set-up and
// finishing steps and 64 restoring division steps, the arithmetic all on the
// one shared 64-bit adder. The next word can be taken in the cycle after the
// code is handed over. With range_max equal to range_min the division is
// skipped. The code also waits while the bit buffer still holds eight or more
// bits or a tail byte, which only output stalls cause. s_ready stays low while
// a sample is in work. Bytes of the previous sample drain to m_* one per cycle
// while m_ready allows, alongside the next calculation; a new code joins the
// bit buffer only once the buffer holds fewer than eight bits. Codes are
// round-half-away-from-zero, wrap through the mask rather than saturate, and
// are zero when range_max equals range_min. bits_per_value 0 acts as 1 and
// values above 30 as 30. Write configuration only with the block idle;
// pending bits survive a change.
// ----------------------------------------------------------------------------
module quantize_bit_packer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  qbp_pkg::in_word_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output qbp_pkg::out_word_t                 m_data,
    input  logic                               cfg_wr_en,
    input  logic [qbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qbp_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import qbp_pkg::*;

    // configuration registers
    logic [NB_W-1:0]           bpv_reg;
    logic signed [RANGE_W-1:0] rmin_reg;
    logic signed [RANGE_W-1:0] rmax_reg;

    logic [NB_W-1:0]  nb;      // clamped code width
    code_word_t       code_w;
    logic             pack_idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpv_reg  <= NB_W'(16);
            rmin_reg <= '0;
            rmax_reg <= RANGE_W'(65536);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BITS_PER_VALUE: bpv_reg  <= cfg_wr_data[NB_W-1:0];
                CFG_RANGE_MIN:      rmin_reg <= cfg_wr_data[RANGE_W-1:0];
                CFG_RANGE_MAX:      rmax_reg <= cfg_wr_data[RANGE_W-1:0];
                default: begin
                    // unmapped index, write ignored
                end
            endcase
        end
    end

    always_comb begin
        if (bpv_reg == '0) begin
            nb = NB_W'(1);
        end else if (bpv_reg > NB_W'(MAX_CODE_BITS)) begin
            nb = NB_W'(MAX_CODE_BITS);
        end else begin
            nb = bpv_reg;
        end
    end

    // sample -> code sequencer
    qbp_quantizer u_quant (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .nb        (nb),
        .range_min (rmin_reg),
        .range_max (rmax_reg),
        .pack_idle (pack_idle),
        .code_o    (code_w)
    );

    // code -> byte stream, with registered output word
    qbp_packer u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .code_i  (code_w),
        .idle    (pack_idle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
